[rtl/voxel_octree_color_pyramid_defines.svh]
// Assertion shorthands shared by the files that check their own logic.
`ifndef VOXEL_OCTREE_COLOR_PYRAMID_DEFINES_SVH
`define VOXEL_OCTREE_COLOR_PYRAMID_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VOCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VOCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vocp_pkg.sv]
`timescale 1ns / 1ps

package vocp_pkg;

    localparam int LEVEL_W     = 4;
    localparam int INDEX_W     = 21;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 3 * CHAN_W;
    localparam int SUM_W       = 11;
    localparam int CNT_W       = 4;
    localparam int WORD_W      = 32;
    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = 4;
    localparam int OUT_FIELDS_W = LEVEL_W + INDEX_W + 1 + COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam logic [2:0] DIGIT_FULL = 3'b111;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_start;
        logic emit;
        logic advance;
        logic next_level;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic check_hit;
        logic div_done;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

[rtl/vocp_ctrl.sv]
`timescale 1ns / 1ps

module vocp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vocp_pkg::t_status i_status,
    output vocp_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.check_hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold the finished parent until the output register frees up.
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        o_cmd.next_level = 1'b1;
                        n_state          = ST_CHECK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/vocp_divider.sv]
`timescale 1ns / 1ps

module vocp_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vocp_pkg::SUM_W-1:0]    i_dividend,
    input  logic [vocp_pkg::CNT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [vocp_pkg::CHAN_W-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [vocp_pkg::STEP_W-1:0]   r_step;
    logic [vocp_pkg::CNT_W-1:0]    r_rem;
    logic [vocp_pkg::CNT_W-1:0]    r_div;
    logic [vocp_pkg::SUM_W-1:0]    r_quo;
    logic [vocp_pkg::CNT_W:0]      trial;
    logic [vocp_pkg::CNT_W:0]      diff;
    logic                          fits;
    logic                          last_step;

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out of the top of r_quo while quotient bits shift in at the bottom.
    always_comb begin
        trial     = {r_rem, r_quo[vocp_pkg::SUM_W-1]};
        fits      = trial >= {1'b0, r_div};
        diff      = trial - {1'b0, r_div};
        last_step = r_step == vocp_pkg::STEP_W'(vocp_pkg::DIV_STEPS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + vocp_pkg::STEP_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[vocp_pkg::CNT_W-1:0] : trial[vocp_pkg::CNT_W-1:0];
            r_quo <= {r_quo[vocp_pkg::SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[vocp_pkg::CHAN_W-1:0];

endmodule

[rtl/vocp_datapath.sv]
`timescale 1ns / 1ps

module vocp_datapath #(
    parameter int MAX_LEVELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vocp_pkg::t_cmd                    i_cmd,
    output vocp_pkg::t_status                 o_status,
    input  logic                              i_cfg_we,
    input  logic [vocp_pkg::LEVEL_W-1:0]      i_cfg_wdata,
    input  logic [vocp_pkg::WORD_W-1:0]       i_word,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [vocp_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);

    localparam int POS_W = 3 * MAX_LEVELS;
    localparam int LW    = vocp_pkg::LEVEL_W;
    localparam int SW    = vocp_pkg::SUM_W;
    localparam int CW    = vocp_pkg::CNT_W;
    localparam int HW    = vocp_pkg::CHAN_W;

    logic [LW-1:0]    r_levels;
    logic [LW-1:0]    lv_eff;
    logic [5:0]       lv_x3;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] pos_mask;
    logic [POS_W+2:0] pos_ext;
    logic [LW-1:0]    r_k;

    logic [SW-1:0] r_red   [MAX_LEVELS];
    logic [SW-1:0] r_green [MAX_LEVELS];
    logic [SW-1:0] r_blue  [MAX_LEVELS];
    logic [CW-1:0] r_cnt   [MAX_LEVELS];
    logic [SW-1:0] n_red   [MAX_LEVELS];
    logic [SW-1:0] n_green [MAX_LEVELS];
    logic [SW-1:0] n_blue  [MAX_LEVELS];
    logic [CW-1:0] n_cnt   [MAX_LEVELS];

    logic [SW-1:0]                     sel_red, sel_green, sel_blue;
    logic [CW-1:0]                     sel_cnt;
    logic [2:0]                        digit_cur, digit_up;
    logic [vocp_pkg::INDEX_W-1:0]      node_index;
    logic [HW-1:0]                     q_red, q_green, q_blue;
    logic [2:0]                        div_done_vec;
    logic                              occ;
    logic [vocp_pkg::COLOR_W-1:0]      color;
    logic                              push_up;
    logic                              voxel_occ;

    logic                              r_out_valid;
    logic [LW-1:0]                     r_out_level;
    logic [vocp_pkg::INDEX_W-1:0]      r_out_index;
    logic                              r_out_occ;
    logic [vocp_pkg::COLOR_W-1:0]      r_out_color;
    logic                              r_out_root;
    logic                              r_out_last;

    // A level count of zero acts as one, and counts above the build limit clamp.
    always_comb begin
        if (r_levels == '0) begin
            lv_eff = LW'(1);
        end else if (r_levels > LW'(MAX_LEVELS)) begin
            lv_eff = LW'(MAX_LEVELS);
        end else begin
            lv_eff = r_levels;
        end
        lv_x3   = {2'b00, lv_eff} + {1'b0, lv_eff, 1'b0};
        pos_inc = r_pos + POS_W'(1);
        for (int i = 0; i < POS_W; i++) begin
            pos_mask[i] = 6'(i) < lv_x3;
        end
        pos_ext = {3'b000, r_pos};
    end

    // Pick the level that the controller is working on.
    always_comb begin
        sel_red    = '0;
        sel_green  = '0;
        sel_blue   = '0;
        sel_cnt    = '0;
        digit_cur  = '0;
        digit_up   = '0;
        node_index = '0;
        for (int j = 0; j < MAX_LEVELS; j++) begin
            if (r_k == LW'(j + 1)) begin
                sel_red    = r_red[j];
                sel_green  = r_green[j];
                sel_blue   = r_blue[j];
                sel_cnt    = r_cnt[j];
                digit_cur  = pos_ext[3*j +: 3];
                digit_up   = pos_ext[3*(j+1) +: 3];
                node_index = vocp_pkg::INDEX_W'(r_pos >> (3 * (j + 1)));
            end
        end
    end

    vocp_divider u_div_red (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sel_red),
        .i_divisor  (sel_cnt),
        .o_done     (div_done_vec[0]),
        .o_quotient (q_red)
    );

    vocp_divider u_div_green (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sel_green),
        .i_divisor  (sel_cnt),
        .o_done     (div_done_vec[1]),
        .o_quotient (q_green)
    );

    vocp_divider u_div_blue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sel_blue),
        .i_divisor  (sel_cnt),
        .o_done     (div_done_vec[2]),
        .o_quotient (q_blue)
    );

    always_comb begin
        occ       = sel_cnt != '0;
        color     = occ ? {q_red, q_green, q_blue} : '0;
        push_up   = i_cmd.emit && (r_k < lv_eff) && occ;
        voxel_occ = i_cmd.accept && (i_word != '0);

        o_status.check_hit = (r_k <= lv_eff) && (digit_cur == vocp_pkg::DIGIT_FULL);
        o_status.emit_last = (r_k == lv_eff) || (digit_up != vocp_pkg::DIGIT_FULL);
        o_status.div_done  = &div_done_vec;
        o_status.out_free  = !r_out_valid || i_m_tready;
    end

    // Each level's accumulator: cleared when its parent is emitted, fed by the
    // parent finished one level below, and level one is fed by the voxels.
    always_comb begin
        for (int j = 0; j < MAX_LEVELS; j++) begin
            n_red[j]   = r_red[j];
            n_green[j] = r_green[j];
            n_blue[j]  = r_blue[j];
            n_cnt[j]   = r_cnt[j];
            if (i_cmd.emit && r_k == LW'(j + 1)) begin
                n_red[j]   = '0;
                n_green[j] = '0;
                n_blue[j]  = '0;
                n_cnt[j]   = '0;
            end
            if (push_up && r_k == LW'(j)) begin
                n_red[j]   = r_red[j] + SW'(color[3*HW-1:2*HW]);
                n_green[j] = r_green[j] + SW'(color[2*HW-1:HW]);
                n_blue[j]  = r_blue[j] + SW'(color[HW-1:0]);
                n_cnt[j]   = r_cnt[j] + CW'(1);
            end
            if (j == 0 && voxel_occ) begin
                n_red[j]   = r_red[j] + SW'(i_word[23:16]);
                n_green[j] = r_green[j] + SW'(i_word[15:8]);
                n_blue[j]  = r_blue[j] + SW'(i_word[7:0]);
                n_cnt[j]   = r_cnt[j] + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= LW'(8);
            r_pos       <= '0;
            r_k         <= LW'(1);
            r_out_valid <= 1'b0;
            for (int j = 0; j < MAX_LEVELS; j++) begin
                r_red[j]   <= '0;
                r_green[j] <= '0;
                r_blue[j]  <= '0;
                r_cnt[j]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                // A new level count starts a fresh volume.
                r_levels <= i_cfg_wdata;
                r_pos    <= '0;
                for (int j = 0; j < MAX_LEVELS; j++) begin
                    r_red[j]   <= '0;
                    r_green[j] <= '0;
                    r_blue[j]  <= '0;
                    r_cnt[j]   <= '0;
                end
            end else begin
                if (i_cmd.advance) begin
                    r_pos <= pos_inc & pos_mask;
                end
                for (int j = 0; j < MAX_LEVELS; j++) begin
                    r_red[j]   <= n_red[j];
                    r_green[j] <= n_green[j];
                    r_blue[j]  <= n_blue[j];
                    r_cnt[j]   <= n_cnt[j];
                end
            end
            if (i_cmd.accept) begin
                r_k <= LW'(1);
            end else if (i_cmd.next_level) begin
                r_k <= r_k + LW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_level <= r_k;
            r_out_index <= node_index;
            r_out_occ   <= occ;
            r_out_color <= color;
            r_out_root  <= r_k == lv_eff;
            r_out_last  <= o_status.emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(vocp_pkg::OUT_TDATA_W - vocp_pkg::OUT_FIELDS_W){1'b0}},
                         r_out_color, r_out_occ, r_out_index, r_out_level};
    assign o_m_tuser  = r_out_root;
    assign o_m_tlast  = r_out_last;

endmodule

[rtl/voxel_octree_color_pyramid.sv]
// Builds a color pyramid over a dense voxel cube streamed in Morton order.
// Slave stream: one 32-bit voxel word per transfer; a nonzero word is occupied.
// Master stream: one word per completed parent node, lowest level first;
// tlast marks the final parent caused by a voxel, tuser marks the root.
// Configuration: i_cfg_we writes the level count and restarts the volume.
// Sequence: a voxel that completes no group passes through accept and
// check only. Each parent that it completes is divided in the three-lane
// restoring divider (11 quotient steps and a done flag) and then waits to
// load the output register; each further parent needs its own check first.
// Reset sets the level count to 8 and clears the position and all level sums.
// The output register holds a word while the receiver stalls; a following
// parent waits behind it, and a new voxel may be accepted while the last
// word of the previous run is still waiting to be taken.
`timescale 1ns / 1ps
`include "voxel_octree_color_pyramid_defines.svh"

module voxel_octree_color_pyramid #(
    parameter int MAX_LEVELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: voxel_word[31:0]
    input  logic [vocp_pkg::WORD_W-1:0]       i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: node_level[3:0], node_index[24:4], node_occupied[25],
    // node_color[49:26], zero fill above
    output logic [vocp_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // tuser: is_root[0]
    output logic                              o_m_tuser,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_we,
    input  logic [vocp_pkg::LEVEL_W-1:0]      i_cfg_wdata
);

    vocp_pkg::t_cmd    w_cmd;
    vocp_pkg::t_status w_status;

    vocp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    vocp_datapath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word      (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    `VOCP_ASSERT_NOW(a_emit_into_free_slot, i_clk, i_rst_n, w_cmd.emit, w_status.out_free, "parent loaded over a word not yet taken")
    `VOCP_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "voxel accepted twice in a row")
    `VOCP_ASSERT_NOW(a_root_ends_run, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast, "root word not marked last")

endmodule

[tb/voxel_octree_color_pyramid_tb.sv]
`timescale 1ns / 1ps

module voxel_octree_color_pyramid_tb;

    localparam int PYRAMID_LEVELS   = 8;
    localparam int LEVELS_AT_RESET  = 8;
    localparam int RESET_CYCLES     = 11;
    localparam int SETTLE_CYCLES    = 48;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int NUM_PHASES       = 9;

    // Receiver stall modes.
    localparam int READY_ALWAYS   = 0;
    localparam int READY_MOSTLY   = 1;
    localparam int READY_SELDOM   = 2;
    localparam int READY_PERIODIC = 3;

    localparam int TDATA_W = vocp_pkg::OUT_TDATA_W;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [vocp_pkg::WORD_W-1:0]   i_s_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [TDATA_W-1:0]            o_m_tdata;
    logic                          o_m_tuser;
    logic                          o_m_tlast;
    logic                          i_cfg_we;
    logic [vocp_pkg::LEVEL_W-1:0]  i_cfg_wdata;

    typedef struct packed {
        logic [vocp_pkg::LEVEL_W-1:0] level;
        logic [vocp_pkg::INDEX_W-1:0] index;
        logic                         occupied;
        logic [vocp_pkg::COLOR_W-1:0] color;
        logic                         root;
        logic                         run_end;
    } t_node;

    class t_pyramid_scoreboard;
        logic [vocp_pkg::LEVEL_W-1:0] levels_reg;
        logic [23:0]                  position;
        logic [vocp_pkg::SUM_W-1:0]   red_acc[PYRAMID_LEVELS];
        logic [vocp_pkg::SUM_W-1:0]   green_acc[PYRAMID_LEVELS];
        logic [vocp_pkg::SUM_W-1:0]   blue_acc[PYRAMID_LEVELS];
        logic [vocp_pkg::CNT_W-1:0]   occ_cnt[PYRAMID_LEVELS];
        t_node                        expected_nodes[$];
        int errors;
        int nodes_checked;
        int roots_seen;
        int deepest_level;
        int voxels_noted;

        function new();
            levels_reg    = 4'(LEVELS_AT_RESET);
            errors        = 0;
            nodes_checked = 0;
            roots_seen    = 0;
            deepest_level = 0;
            voxels_noted  = 0;
            clear_volume();
        endfunction

        function void clear_volume();
            position = '0;
            for (int s = 0; s < PYRAMID_LEVELS; s++) begin
                red_acc[s]   = '0;
                green_acc[s] = '0;
                blue_acc[s]  = '0;
                occ_cnt[s]   = '0;
            end
        endfunction

        function void set_levels(logic [vocp_pkg::LEVEL_W-1:0] value);
            levels_reg = value;
            clear_volume();
        endfunction

        // Zero acts as a single level and anything above the build size is clamped.
        function int active_levels();
            if (levels_reg == 0) return 1;
            if (levels_reg > PYRAMID_LEVELS) return PYRAMID_LEVELS;
            return levels_reg;
        endfunction

        function void add_child(int slot, logic [23:0] rgb);
            red_acc[slot]   += 11'(rgb[23:16]);
            green_acc[slot] += 11'(rgb[15:8]);
            blue_acc[slot]  += 11'(rgb[7:0]);
            occ_cnt[slot]   += 4'd1;
        endfunction

        function int pending();
            return expected_nodes.size();
        endfunction

        function void note_voxel(logic [31:0] word);
            int          lv;
            logic [23:0] mask;
            logic [23:0] pos;
            logic [23:0] rgb;
            t_node       node;
            lv   = active_levels();
            mask = 24'((32'd1 << (3 * lv)) - 1);
            pos  = position & mask;
            voxels_noted++;
            if (word != 0) add_child(0, word[23:0]);
            for (int k = 1; k <= lv; k++) begin
                if (3'(pos >> (3 * (k - 1))) != vocp_pkg::DIGIT_FULL) break;
                rgb = '0;
                if (occ_cnt[k-1] != 0) begin
                    rgb[23:16] = 8'(red_acc[k-1] / occ_cnt[k-1]);
                    rgb[15:8]  = 8'(green_acc[k-1] / occ_cnt[k-1]);
                    rgb[7:0]   = 8'(blue_acc[k-1] / occ_cnt[k-1]);
                end
                node.level    = 4'(k);
                node.index    = 21'(pos >> (3 * k));
                node.occupied = (occ_cnt[k-1] != 0);
                node.color    = rgb;
                node.root     = (k == lv);
                // The run ends here unless the next level's group is completed too.
                node.run_end  = !(k < lv && 3'(pos >> (3 * k)) == vocp_pkg::DIGIT_FULL);
                expected_nodes = {expected_nodes, node};
                red_acc[k-1]   = '0;
                green_acc[k-1] = '0;
                blue_acc[k-1]  = '0;
                occ_cnt[k-1]   = '0;
                if (k < lv && node.occupied) add_child(k, rgb);
            end
            position = (pos + 24'd1) & mask;
        endfunction

        task report_mismatch(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch at parent %0d: expected 0x%0h, got 0x%0h",
                     $time, field, nodes_checked, want, got);
            errors++;
        endtask

        task check_node(logic [TDATA_W-1:0] data, logic user, logic last_flag);
            t_node want;
            if (expected_nodes.size() == 0) begin
                report_mismatch("unexpected parent word", 0, data);
                return;
            end
            want = expected_nodes.pop_front();
            nodes_checked++;
            if (data[3:0] != want.level) report_mismatch("node_level", want.level, data[3:0]);
            if (data[24:4] != want.index) report_mismatch("node_index", want.index, data[24:4]);
            if (data[25] != want.occupied)
                report_mismatch("node_occupied", want.occupied, data[25]);
            if (data[49:26] != want.color) report_mismatch("node_color", want.color, data[49:26]);
            if (data[TDATA_W-1:50] != 0) report_mismatch("tdata fill", 0, data[TDATA_W-1:50]);
            if (user != want.root) report_mismatch("is_root", want.root, user);
            if (last_flag != want.run_end) report_mismatch("last_of_run", want.run_end, last_flag);
            if (want.root) roots_seen++;
            if (want.level > deepest_level) deepest_level = int'(want.level);
        endtask
    endclass

    t_pyramid_scoreboard sb = new();

    int          burst_left    = 0;
    int          cfg_writes    = 0;
    bit          hold_request  = 1'b0;
    int          phase_levels[NUM_PHASES] = '{1, 2, 3, 8, 0, 15, 9, 2, 1};
    int          phase_items[NUM_PHASES]  = '{40, 128, 72, 16, 24, 16, 16, 40, 16};
    int          phase_empty[NUM_PHASES]  = '{30, 50, 20, 60, 40, 85, 10, 90, 0};
    logic [31:0] mixed_extremes[8] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFF00_0000,
                                       32'h00FF_FFFF, 32'h00FF_0000, 32'h0000_FF00,
                                       32'h0000_00FF, 32'h7F01_0203};

    voxel_octree_color_pyramid #(
        .MAX_LEVELS (PYRAMID_LEVELS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_voxel(input logic [31:0] word);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_voxel(word);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic settle_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // A voxel that completes no group gives no result, so the block may still
    // be busy after the last parent; give it time before the write.
    task automatic write_levels(input logic [vocp_pkg::LEVEL_W-1:0] value);
        settle_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_levels(value);
        cfg_writes++;
    endtask

    function automatic logic [31:0] random_voxel(int empty_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < empty_pct) return '0;
        if (pick < empty_pct + 8) return {8'($urandom_range(1, 255)), 24'h0};
        if (pick < empty_pct + 14) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
        return $urandom;
    endfunction

    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        mode      = READY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                sb.check_node(o_m_tdata, o_m_tuser, o_m_tlast);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(READY_ALWAYS, READY_PERIODIC);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    READY_ALWAYS: i_m_tready <= 1'b1;
                    READY_MOSTLY: i_m_tready <= ($urandom_range(0, 9) < 8);
                    READY_SELDOM: i_m_tready <= ($urandom_range(0, 9) < 3);
                    default:      i_m_tready <= ((mode_left % 5) < 3);
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout after %0d cycles with no word moving, %0d parents still expected",
                 quiet, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset level count: one level-one parent from extreme words, black included.
        foreach (mixed_extremes[i]) send_voxel(mixed_extremes[i]);

        // Zero acts as one level: an empty root, then the volume wraps and a
        // partial group is abandoned by the next write.
        write_levels(4'd0);
        repeat (8) send_voxel('0);
        repeat (3) send_voxel(32'h0010_2030);

        // Fifteen clamps to the build size; the group must start from scratch.
        write_levels(4'd15);
        for (int i = 0; i < 8; i++) send_voxel(i[0] ? 32'h0102_0304 : 32'hFF00_0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_levels(4'(phase_levels[p]));
            if (p == 0) hold_request = 1'b1;
            for (int i = 0; i < phase_items[p]; i++) begin
                if (p == 1 && i == phase_items[p] / 2) settle_idle();
                pace_sender();
                send_voxel(random_voxel(phase_empty[p]));
            end
        end

        settle_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Streamed %0d voxels under %0d level-count writes, clamped values included.",
                 sb.voxels_noted, cfg_writes);
        $display("Checked %0d parents (%0d roots, up to level %0d); %0d mismatches.",
                 sb.nodes_checked, sb.roots_seen, sb.deepest_level, sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/vocp_pkg.sv
rtl/vocp_ctrl.sv
rtl/vocp_divider.sv
rtl/vocp_datapath.sv
rtl/voxel_octree_color_pyramid.sv
tb/voxel_octree_color_pyramid_tb.sv
